@@ src/bpm_pkg.sv @@
// Shared constants, payload structs and arithmetic helpers for the BPM position block.
// Depends on nothing; every other file in src refers to it by scoped names.
package bpm_pkg;

  // Field widths
  localparam int SAMPLE_W   = 16;
  localparam int FRAC_W     = 16;
  localparam int SCALE_W    = 8;
  localparam int CTR_W      = 10;
  localparam int PIX_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = CTR_W;

  // Ratio magnitude is clipped to 8.0, so the quotient needs FRAC_W + 4 bits
  localparam int Q_W        = FRAC_W + 4;
  localparam int OVF_SHIFT  = Q_W - FRAC_W + 1;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = Q_W / DIV_STEPS;

  // Correction polynomial widths
  localparam int SQ_W       = 2 * Q_W;
  localparam int SUM_W      = SQ_W + 1;
  localparam int FAC_W      = SQ_W - FRAC_W;
  localparam int PROD1_W    = Q_W + FAC_W;
  localparam int M_W        = PROD1_W - FRAC_W;
  localparam int PROD2_W    = M_W + SCALE_W;
  localparam int OFS_W      = PROD2_W - FRAC_W;
  localparam int PIXSUM_W   = OFS_W + 2;

  // Pipeline stage map
  localparam int ST_FRONT = 0;
  localparam int ST_DIV   = ST_FRONT + 1;
  localparam int ST_CLIP  = ST_DIV + DIV_STAGES;
  localparam int ST_FAC   = ST_CLIP + 1;
  localparam int ST_MUL   = ST_FAC + 1;
  localparam int ST_OFS   = ST_MUL + 1;
  localparam int ST_PIX   = ST_OFS + 1;
  localparam int STAGES   = ST_PIX + 1;

  localparam logic [Q_W-1:0]      LIM_NEG = {1'b1, {(Q_W-1){1'b0}}};
  localparam logic [Q_W-1:0]      LIM_POS = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic [SUM_W-1:0]    ONE_SQ  = SUM_W'(1) << (2 * FRAC_W);
  localparam logic signed [PIXSUM_W-1:0] PIX_HI = PIXSUM_W'((1 << (PIX_W-1)) - 1);
  localparam logic signed [PIXSUM_W-1:0] PIX_LO = ~PIX_HI;

  localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(80);
  localparam logic [CTR_W-1:0]   CTR_RST   = CTR_W'(75);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE = 2'd0,
    CFG_CX    = 2'd1,
    CFG_CY    = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [STAGES-1:0] load;
  } pipe_ctl_t;

  // One channel of the restoring divider in flight
  typedef struct packed {
    logic [SAMPLE_W-1:0] dvs;
    logic [SAMPLE_W-1:0] rem;
    logic [Q_W-1:0]      num;
    logic [Q_W-1:0]      quo;
    logic                neg;
    logic                ovf;
  } div_lane_t;

  typedef struct packed {
    logic [Q_W-1:0] quo;
    logic           neg;
    logic           ovf;
  } ratio_t;

  typedef struct packed {
    logic [OFS_W-1:0] mag;
    logic             neg;
  } offset_t;

  // One restoring step: shift in the next numerator bit, subtract if it fits
  function automatic div_lane_t div_iter(input div_lane_t d);
    div_lane_t           r;
    logic [SAMPLE_W:0]   s;
    logic [SAMPLE_W:0]   diff;
    logic                take;
    s    = {d.rem, d.num[Q_W-1]};
    diff = s - {1'b0, d.dvs};
    take = (s >= {1'b0, d.dvs});
    r     = d;
    r.num = {d.num[Q_W-2:0], 1'b0};
    r.rem = take ? diff[SAMPLE_W-1:0] : s[SAMPLE_W-1:0];
    r.quo = {d.quo[Q_W-2:0], take};
    return r;
  endfunction

  // Clip a quotient magnitude to the ratio range; top bit flags the clip
  function automatic logic [Q_W:0] clip_ratio(input ratio_t r);
    logic [Q_W-1:0] lim;
    lim = r.neg ? LIM_NEG : LIM_POS;
    if (r.ovf || (r.quo > lim)) begin
      return {1'b1, lim};
    end
    return {1'b0, r.quo};
  endfunction

endpackage

@@ src/bpm_position_from_sum_dif.sv @@
// Top level of the BPM position block: front end, divider, correction, pixel stage.
// Depends on bpm_pkg, bpm_ctrl, bpm_div and bpm_poly.
//
// Turns one beam position monitor sample set (x/z sum and difference) into a
// screen pixel. Ratios dif/(2*|sum|) are formed as signed Q4.16 and clipped to
// plus or minus 8, a cubic correction xt*(1+xt^2+zt^2)*position_scale gives
// the pixel offset, and the result center_x+x, center_y-z is clipped to int16.
// A missing sample or a zero sum returns (0, center_y - center_y/2) with
// used_fallback set. The block takes one beat per cycle on in and delivers one
// per cycle on out while out_ready is high. Its stages are the front end,
// the pipelined divider that resolves the 20-bit quotient 4 bits per stage
// (5 stages), the square, factor and two product stages, and the
// output register. A stall on out back-fills empty stages before in_ready
// drops. Configuration writes are taken at any time (cfg_ready is always
// high) but must only be issued while the pipeline is empty.
module bpm_position_from_sum_dif (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [bpm_pkg::SAMPLE_W-1:0] sum_x,
  input  logic signed [bpm_pkg::SAMPLE_W-1:0] sum_z,
  input  logic signed [bpm_pkg::SAMPLE_W-1:0] dif_x,
  input  logic signed [bpm_pkg::SAMPLE_W-1:0] dif_z,
  input  logic                           sample_present,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [bpm_pkg::PIX_W-1:0] pixel_x,
  output logic signed [bpm_pkg::PIX_W-1:0] pixel_y,
  output logic                           used_fallback,
  output logic                           saturated,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bpm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpm_pkg::CFG_DATA_W-1:0] cfg_data
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [bpm_pkg::SCALE_W-1:0] position_scale;
  logic [bpm_pkg::CTR_W-1:0]   center_x;
  logic [bpm_pkg::CTR_W-1:0]   center_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      position_scale <= bpm_pkg::SCALE_RST;
      center_x       <= bpm_pkg::CTR_RST;
      center_y       <= bpm_pkg::CTR_RST;
    end else if (cfg_valid) begin
      case (bpm_pkg::cfg_reg_t'(cfg_index))
        bpm_pkg::CFG_SCALE: position_scale <= cfg_data[bpm_pkg::SCALE_W-1:0];
        bpm_pkg::CFG_CX:    center_x       <= cfg_data[bpm_pkg::CTR_W-1:0];
        bpm_pkg::CFG_CY:    center_y       <= cfg_data[bpm_pkg::CTR_W-1:0];
        default: begin
          // drop writes to unmapped indexes
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline control
  // ---------------------------------------------------------------------
  bpm_pkg::pipe_ctl_t ctl;

  bpm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  // ---------------------------------------------------------------------
  // Front end: magnitudes, divider seed, overflow and fallback detection
  // ---------------------------------------------------------------------
  // Quotient = floor(|dif| * 2^(F-1) / |sum|). The top bits of the numerator
  // seed the remainder; if they already reach the divisor the quotient is
  // beyond the clip range and only the overflow flag matters.
  function automatic bpm_pkg::div_lane_t make_lane(
    input logic [bpm_pkg::SAMPLE_W-1:0] sum,
    input logic [bpm_pkg::SAMPLE_W-1:0] dif
  );
    bpm_pkg::div_lane_t          l;
    logic [bpm_pkg::SAMPLE_W-1:0] ms;
    logic [bpm_pkg::SAMPLE_W-1:0] md;
    logic [bpm_pkg::SAMPLE_W-1:0] hi;
    ms = sum[bpm_pkg::SAMPLE_W-1] ? (~sum + 1'b1) : sum;
    md = dif[bpm_pkg::SAMPLE_W-1] ? (~dif + 1'b1) : dif;
    hi = md >> bpm_pkg::OVF_SHIFT;
    l.dvs = ms;
    l.rem = hi;
    l.num = {md[bpm_pkg::OVF_SHIFT-1:0], {(bpm_pkg::FRAC_W-1){1'b0}}};
    l.quo = '0;
    l.neg = dif[bpm_pkg::SAMPLE_W-1];
    l.ovf = (hi >= ms);
    return l;
  endfunction

  bpm_pkg::div_lane_t     lane_x, lane_z;
  logic [bpm_pkg::ST_OFS:0] fb_line;
  logic                   fb_next;

  assign fb_next = !sample_present || (sum_x == '0) || (sum_z == '0);

  always_ff @(posedge clk) begin
    if (ctl.load[bpm_pkg::ST_FRONT]) begin
      lane_x     <= make_lane(sum_x, dif_x);
      lane_z     <= make_lane(sum_z, dif_z);
      fb_line[0] <= fb_next;
    end
    // Fallback flag rides alongside the arithmetic stages
    for (int k = 1; k <= bpm_pkg::ST_OFS; k++) begin
      if (ctl.load[k]) begin
        fb_line[k] <= fb_line[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Dividers and correction polynomial
  // ---------------------------------------------------------------------
  bpm_pkg::ratio_t  ratio_x, ratio_z;
  bpm_pkg::offset_t ofs_x, ofs_z;
  logic             ratio_sat;

  bpm_div u_div_x (
    .clk     (clk),
    .ctl     (ctl),
    .lane_in (lane_x),
    .ratio   (ratio_x)
  );

  bpm_div u_div_z (
    .clk     (clk),
    .ctl     (ctl),
    .lane_in (lane_z),
    .ratio   (ratio_z)
  );

  bpm_poly u_poly (
    .clk       (clk),
    .ctl       (ctl),
    .rx        (ratio_x),
    .rz        (ratio_z),
    .scale     (position_scale),
    .ofs_x     (ofs_x),
    .ofs_z     (ofs_z),
    .ratio_sat (ratio_sat)
  );

  // ---------------------------------------------------------------------
  // Pixel stage and output register
  // ---------------------------------------------------------------------
  function automatic logic [bpm_pkg::PIX_W:0] clip_pix(
    input logic signed [bpm_pkg::PIXSUM_W-1:0] v
  );
    if (v > bpm_pkg::PIX_HI) begin
      return {1'b1, bpm_pkg::PIX_HI[bpm_pkg::PIX_W-1:0]};
    end
    if (v < bpm_pkg::PIX_LO) begin
      return {1'b1, bpm_pkg::PIX_LO[bpm_pkg::PIX_W-1:0]};
    end
    return {1'b0, v[bpm_pkg::PIX_W-1:0]};
  endfunction

  logic signed [bpm_pkg::PIXSUM_W-1:0] off_x, off_z, px_full, py_full;
  logic [bpm_pkg::PIX_W:0]             cpx, cpy;
  logic [bpm_pkg::CTR_W-1:0]           fb_y;

  // Offset sign is applied after truncation, so it rounds toward zero
  assign off_x = ofs_x.neg ? -$signed({2'b00, ofs_x.mag}) : $signed({2'b00, ofs_x.mag});
  assign off_z = ofs_z.neg ? -$signed({2'b00, ofs_z.mag}) : $signed({2'b00, ofs_z.mag});
  assign px_full = $signed({{(bpm_pkg::PIXSUM_W-bpm_pkg::CTR_W){1'b0}}, center_x}) + off_x;
  assign py_full = $signed({{(bpm_pkg::PIXSUM_W-bpm_pkg::CTR_W){1'b0}}, center_y}) - off_z;
  assign cpx     = clip_pix(px_full);
  assign cpy     = clip_pix(py_full);
  assign fb_y    = center_y - (center_y >> 1);

  always_ff @(posedge clk) begin
    if (ctl.load[bpm_pkg::ST_PIX]) begin
      if (fb_line[bpm_pkg::ST_OFS]) begin
        pixel_x       <= '0;
        pixel_y       <= {{(bpm_pkg::PIX_W-bpm_pkg::CTR_W){1'b0}}, fb_y};
        used_fallback <= 1'b1;
        saturated     <= 1'b0;
      end else begin
        pixel_x       <= cpx[bpm_pkg::PIX_W-1:0];
        pixel_y       <= cpy[bpm_pkg::PIX_W-1:0];
        used_fallback <= 1'b0;
        saturated     <= ratio_sat | cpx[bpm_pkg::PIX_W] | cpy[bpm_pkg::PIX_W];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  a_fallback_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && used_fallback |-> !saturated && (pixel_x == '0))
    else $error("fallback beat carries saturation or nonzero column");

  a_empty_accepts: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while output stage is empty");

  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("output beat present right after reset");

endmodule

@@ src/bpm_ctrl.sv @@
// Valid tracking and per-stage load enables for the position pipeline.
// Depends on bpm_pkg for the stage count and the control struct.
module bpm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output bpm_pkg::pipe_ctl_t ctl
);

  logic [bpm_pkg::STAGES-1:0] valid;
  logic [bpm_pkg::STAGES:0]   ready;

  // A stage may load when it is empty or its contents move on
  always_comb begin
    ready[bpm_pkg::STAGES] = out_ready;
    for (int k = bpm_pkg::STAGES - 1; k >= 0; k--) begin
      ready[k] = !valid[k] || ready[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (ready[0]) begin
        valid[0] <= in_valid;
      end
      for (int k = 1; k < bpm_pkg::STAGES; k++) begin
        if (ready[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  assign ctl.load  = ready[bpm_pkg::STAGES-1:0];
  assign in_ready  = ready[0];
  assign out_valid = valid[bpm_pkg::STAGES-1];

endmodule

@@ src/bpm_div.sv @@
// Pipelined restoring divider for one channel: a few quotient bits per stage.
// Depends on bpm_pkg for the lane struct and the step function.
module bpm_div (
  input  logic                clk,
  input  bpm_pkg::pipe_ctl_t  ctl,
  input  bpm_pkg::div_lane_t  lane_in,
  output bpm_pkg::ratio_t     ratio
);

  bpm_pkg::div_lane_t stage      [bpm_pkg::DIV_STAGES];
  bpm_pkg::div_lane_t stage_next [bpm_pkg::DIV_STAGES];

  for (genvar k = 0; k < bpm_pkg::DIV_STAGES; k++) begin : g_stage
    bpm_pkg::div_lane_t src;

    if (k == 0) begin : g_first
      assign src = lane_in;
    end else begin : g_rest
      assign src = stage[k-1];
    end

    always_comb begin
      stage_next[k] = src;
      for (int i = 0; i < bpm_pkg::DIV_STEPS; i++) begin
        stage_next[k] = bpm_pkg::div_iter(stage_next[k]);
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.load[bpm_pkg::ST_DIV + k]) begin
        stage[k] <= stage_next[k];
      end
    end
  end

  assign ratio.quo = stage[bpm_pkg::DIV_STAGES-1].quo;
  assign ratio.neg = stage[bpm_pkg::DIV_STAGES-1].neg;
  assign ratio.ovf = stage[bpm_pkg::DIV_STAGES-1].ovf;

endmodule

@@ src/bpm_poly.sv @@
// Ratio clip and cubic correction: square, factor, two scaled products.
// Depends on bpm_pkg for widths, stage map and the clip function.
module bpm_poly (
  input  logic                        clk,
  input  bpm_pkg::pipe_ctl_t          ctl,
  input  bpm_pkg::ratio_t             rx,
  input  bpm_pkg::ratio_t             rz,
  input  logic [bpm_pkg::SCALE_W-1:0] scale,
  output bpm_pkg::offset_t            ofs_x,
  output bpm_pkg::offset_t            ofs_z,
  output logic                        ratio_sat
);

  // Clip and square
  logic [bpm_pkg::Q_W:0]    clip_x, clip_z;
  logic [bpm_pkg::SQ_W-1:0] sqx_next, sqz_next;
  logic [bpm_pkg::Q_W-1:0]  ax1, az1;
  logic [bpm_pkg::SQ_W-1:0] sqx1, sqz1;
  logic                     negx1, negz1, sat1;

  assign clip_x   = bpm_pkg::clip_ratio(rx);
  assign clip_z   = bpm_pkg::clip_ratio(rz);
  assign sqx_next = bpm_pkg::SQ_W'(clip_x[bpm_pkg::Q_W-1:0])
                  * bpm_pkg::SQ_W'(clip_x[bpm_pkg::Q_W-1:0]);
  assign sqz_next = bpm_pkg::SQ_W'(clip_z[bpm_pkg::Q_W-1:0])
                  * bpm_pkg::SQ_W'(clip_z[bpm_pkg::Q_W-1:0]);

  always_ff @(posedge clk) begin
    if (ctl.load[bpm_pkg::ST_CLIP]) begin
      ax1   <= clip_x[bpm_pkg::Q_W-1:0];
      az1   <= clip_z[bpm_pkg::Q_W-1:0];
      sqx1  <= sqx_next;
      sqz1  <= sqz_next;
      negx1 <= rx.neg;
      negz1 <= rz.neg;
      sat1  <= clip_x[bpm_pkg::Q_W] | clip_z[bpm_pkg::Q_W];
    end
  end

  // Factor (1 + xt^2 + zt^2), truncated to FRAC_W fraction bits
  logic [bpm_pkg::SUM_W-1:0] fac_sum;
  logic [bpm_pkg::FAC_W-1:0] fac2;
  logic [bpm_pkg::Q_W-1:0]   ax2, az2;
  logic                      negx2, negz2, sat2;

  assign fac_sum = bpm_pkg::ONE_SQ + bpm_pkg::SUM_W'(sqx1) + bpm_pkg::SUM_W'(sqz1);

  always_ff @(posedge clk) begin
    if (ctl.load[bpm_pkg::ST_FAC]) begin
      fac2  <= fac_sum[bpm_pkg::FRAC_W +: bpm_pkg::FAC_W];
      ax2   <= ax1;
      az2   <= az1;
      negx2 <= negx1;
      negz2 <= negz1;
      sat2  <= sat1;
    end
  end

  // Ratio times factor
  logic [bpm_pkg::PROD1_W-1:0] p1x, p1z;
  logic [bpm_pkg::M_W-1:0]     mx3, mz3;
  logic                        negx3, negz3, sat3;

  assign p1x = bpm_pkg::PROD1_W'(ax2) * bpm_pkg::PROD1_W'(fac2);
  assign p1z = bpm_pkg::PROD1_W'(az2) * bpm_pkg::PROD1_W'(fac2);

  always_ff @(posedge clk) begin
    if (ctl.load[bpm_pkg::ST_MUL]) begin
      mx3   <= p1x[bpm_pkg::FRAC_W +: bpm_pkg::M_W];
      mz3   <= p1z[bpm_pkg::FRAC_W +: bpm_pkg::M_W];
      negx3 <= negx2;
      negz3 <= negz2;
      sat3  <= sat2;
    end
  end

  // Scale to pixels
  logic [bpm_pkg::PROD2_W-1:0] p2x, p2z;

  assign p2x = bpm_pkg::PROD2_W'(mx3) * bpm_pkg::PROD2_W'(scale);
  assign p2z = bpm_pkg::PROD2_W'(mz3) * bpm_pkg::PROD2_W'(scale);

  always_ff @(posedge clk) begin
    if (ctl.load[bpm_pkg::ST_OFS]) begin
      ofs_x.mag <= p2x[bpm_pkg::FRAC_W +: bpm_pkg::OFS_W];
      ofs_z.mag <= p2z[bpm_pkg::FRAC_W +: bpm_pkg::OFS_W];
      ofs_x.neg <= negx3;
      ofs_z.neg <= negz3;
      ratio_sat <= sat3;
    end
  end

endmodule
